// File: hw/rtl/ntpcal_pkg.sv
// Shared widths, constants and helper functions for the NTP seconds to calendar core.
// Depends on nothing; every other file of the block imports it.

package ntpcal_pkg;

  localparam int unsigned NTP_SECONDS_W = 32;
  localparam int unsigned ZONE_OFFSET_W = 17;
  localparam int unsigned HOUR_W        = 5;
  localparam int unsigned MINUTE_W      = 6;
  localparam int unsigned SECOND_W      = 6;
  localparam int unsigned DAY_W         = 5;
  localparam int unsigned MONTH_W       = 4;
  localparam int unsigned YEAR_W        = 7;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ZONE_OFFSET_ADDR = 3'd0;

  localparam logic [32:0] SECS_PER_DAY = 33'd86400;
  localparam logic [17:0] DAYS_400Y    = 18'd146097;
  localparam logic [17:0] DAY_BIAS_ERA = 18'd109512;

  // Reciprocals m = ceil(2^sh / d), exact for every operand of the stated width.
  localparam int unsigned D675_SH = 36;
  localparam logic [26:0] D675_M  = 27'(((64'd1 << D675_SH) + 64'd674) / 64'd675);
  localparam int unsigned D60S_SH = 23;
  localparam logic [17:0] D60S_M  = 18'(((64'd1 << D60S_SH) + 64'd59) / 64'd60);
  localparam int unsigned D60M_SH = 17;
  localparam logic [11:0] D60M_M  = 12'(((64'd1 << D60M_SH) + 64'd59) / 64'd60);
  localparam int unsigned D1460_SH = 29;
  localparam logic [18:0] D1460_M  = 19'(((64'd1 << D1460_SH) + 64'd1459) / 64'd1460);
  localparam int unsigned D36524_SH = 34;
  localparam logic [18:0] D36524_M  = 19'(((64'd1 << D36524_SH) + 64'd36523) / 64'd36524);
  localparam int unsigned D365_SH = 27;
  localparam logic [18:0] D365_M  = 19'(((64'd1 << D365_SH) + 64'd364) / 64'd365);
  localparam int unsigned D100_SH = 16;
  localparam logic [9:0]  D100_M  = 10'(((64'd1 << D100_SH) + 64'd99) / 64'd100);
  localparam int unsigned D153_SH = 19;
  localparam logic [11:0] D153_M  = 12'(((64'd1 << D153_SH) + 64'd152) / 64'd153);

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } hms_t;

  // Day of the March-based year on which each month starts, March first.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/ntpcal_sec_if.sv
// Input channel of the calendar core: valid/ready handshake carrying NTP whole seconds.
// Depends on ntpcal_pkg for the field width.

interface ntpcal_sec_if import ntpcal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [NTP_SECONDS_W-1:0] ntp_seconds;

  modport source (output valid, output ntp_seconds, input ready);
  modport sink (input valid, input ntp_seconds, output ready);
endinterface

// File: hw/rtl/ntpcal_cal_if.sv
// Output channel of the calendar core: valid/ready handshake carrying the calendar fields.
// Depends on ntpcal_pkg for the field widths.

interface ntpcal_cal_if import ntpcal_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HOUR_W-1:0]   hour_of_day;
  logic [MINUTE_W-1:0] minute_of_hour;
  logic [SECOND_W-1:0] second_of_minute;
  logic [DAY_W-1:0]    day_of_month;
  logic [MONTH_W-1:0]  month_number;
  logic [YEAR_W-1:0]   year_of_century;

  modport source (output valid, output hour_of_day, output minute_of_hour,
                  output second_of_minute, output day_of_month, output month_number,
                  output year_of_century, input ready);
  modport sink (input valid, input hour_of_day, input minute_of_hour,
                input second_of_minute, input day_of_month, input month_number,
                input year_of_century, output ready);
endinterface

// File: hw/rtl/ntp_seconds_to_calendar_core.sv
// Top level: converts NTP whole seconds plus a zone offset into calendar fields.
// Depends on ntpcal_pkg, ntpcal_sec_if and ntpcal_cal_if.
//
//   Channel   Kind         Transaction
//   sec_i     valid/ready  one NTP seconds value in
//   cal_o     valid/ready  hour, minute, second, day, month, year of century out
//   APB       psel/penable write or read of the zone offset register
//
// Eleven register stages; a new transaction can enter every cycle unless a stall at the output
// has filled the pipeline. The longest stage holds one constant-reciprocal multiply.
// Each stage advances when it is empty or the stage after it advances, so a stall at
// the output fills the bubbles behind it before the input is held. Reset clears the
// valid bits and sets the offset to zero.

module ntp_seconds_to_calendar_core import ntpcal_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ntpcal_sec_if.sink            sec_i,
  ntpcal_cal_if.source          cal_o,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output logic                  pready_o
);

  localparam int unsigned NS = 11;

  logic [ZONE_OFFSET_W-1:0] zone_q;
  logic [NS:1]              v_q;
  logic [NS:1]              en;

  // Configuration port.
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && paddr_i == ZONE_OFFSET_ADDR) begin
      zone_q <= pwdata_i[ZONE_OFFSET_W-1:0];
    end
  end

  always_comb begin
    if (paddr_i == ZONE_OFFSET_ADDR) begin
      prdata_o = {{(APB_DATA_W-ZONE_OFFSET_W){zone_q[ZONE_OFFSET_W-1]}}, zone_q};
    end else begin
      prdata_o = '0;
    end
  end

  // Stage flow control.
  always_comb begin
    en[NS] = !v_q[NS] || cal_o.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign sec_i.ready = en[1];
  assign cal_o.valid = v_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= sec_i.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: add the offset and one day, split off the factor of 128 in 86400.
  logic [32:0] shifted;
  logic [25:0] s1_x_q;
  logic [6:0]  s1_lo_q;

  assign shifted = {1'b0, sec_i.ntp_seconds}
                 + {{(33-ZONE_OFFSET_W){zone_q[ZONE_OFFSET_W-1]}}, zone_q}
                 + SECS_PER_DAY;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_x_q  <= shifted[32:7];
      s1_lo_q <= shifted[6:0];
    end
  end

  // Stage 2: day number by reciprocal of 675.
  logic [52:0] q_prod;
  logic [16:0] s2_q_q;
  logic [25:0] s2_x_q;
  logic [6:0]  s2_lo_q;

  assign q_prod = s1_x_q * D675_M;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_q_q  <= q_prod[52:36];
      s2_x_q  <= s1_x_q;
      s2_lo_q <= s1_lo_q;
    end
  end

  // Stage 3: second of day, and day count rebased to the start of a 400-year era.
  logic [26:0] q675;
  logic [25:0] rem_full;
  logic [16:0] s3_sod_q;
  logic [17:0] s3_d0_q;

  assign q675     = s2_q_q * 10'd675;
  assign rem_full = s2_x_q - q675[25:0];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_sod_q <= {rem_full[9:0], s2_lo_q};
      s3_d0_q  <= {1'b0, s2_q_q} + DAY_BIAS_ERA;
    end
  end

  // Stage 4: day of era, minutes of day.
  logic [34:0] mins_prod;
  logic [17:0] s4_doe_q;
  logic [16:0] s4_sod_q;
  logic [10:0] s4_mins_q;

  assign mins_prod = s3_sod_q * D60S_M;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_doe_q  <= (s3_d0_q >= DAYS_400Y) ? s3_d0_q - DAYS_400Y : s3_d0_q;
      s4_sod_q  <= s3_sod_q;
      s4_mins_q <= mins_prod[33:23];
    end
  end

  // Stage 5: leap corrections of the era, second and hour.
  logic [16:0] m60;
  logic [16:0] sec_full;
  logic [22:0] hour_prod;
  logic [36:0] a_prod;
  logic [36:0] b_prod;
  logic [17:0] s5_doe_q;
  logic [6:0]  s5_a_q;
  logic [2:0]  s5_b_q;
  logic        s5_c_q;
  logic [5:0]  s5_sec_q;
  logic [10:0] s5_mins_q;
  logic [4:0]  s5_hour_q;

  assign m60       = s4_mins_q * 6'd60;
  assign sec_full  = s4_sod_q - m60;
  assign hour_prod = s4_mins_q * D60M_M;
  assign a_prod    = s4_doe_q * D1460_M;
  assign b_prod    = s4_doe_q * D36524_M;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_doe_q  <= s4_doe_q;
      s5_a_q    <= a_prod[35:29];
      s5_b_q    <= b_prod[36:34];
      s5_c_q    <= (s4_doe_q == DAYS_400Y - 18'd1);
      s5_sec_q  <= sec_full[5:0];
      s5_mins_q <= s4_mins_q;
      s5_hour_q <= hour_prod[21:17];
    end
  end

  // Stage 6: leap-adjusted day count and minute.
  logic [10:0] h60;
  logic [10:0] min_full;
  logic [17:0] s6_doe_q;
  logic [17:0] s6_t_q;
  hms_t        s6_tm_q;

  assign h60      = s5_hour_q * 6'd60;
  assign min_full = s5_mins_q - h60;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_doe_q       <= s5_doe_q;
      s6_t_q         <= s5_doe_q - {11'd0, s5_a_q} + {15'd0, s5_b_q} - {17'd0, s5_c_q};
      s6_tm_q.hour   <= s5_hour_q;
      s6_tm_q.minute <= min_full[5:0];
      s6_tm_q.second <= s5_sec_q;
    end
  end

  // Stage 7: year of era.
  logic [36:0] yoe_prod;
  logic [17:0] s7_doe_q;
  logic [8:0]  s7_yoe_q;
  hms_t        s7_tm_q;

  assign yoe_prod = s6_t_q * D365_M;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_doe_q <= s6_doe_q;
      s7_yoe_q <= yoe_prod[35:27];
      s7_tm_q  <= s6_tm_q;
    end
  end

  // Stage 8: day on which the year of era starts, without the century term.
  logic [17:0] yoe365;
  logic [18:0] y100_prod;
  logic [17:0] s8_doe_q;
  logic [8:0]  s8_yoe_q;
  logic [17:0] s8_base_q;
  logic [2:0]  s8_y100_q;
  hms_t        s8_tm_q;

  assign yoe365    = s7_yoe_q * 9'd365;
  assign y100_prod = s7_yoe_q * D100_M;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_doe_q  <= s7_doe_q;
      s8_yoe_q  <= s7_yoe_q;
      s8_base_q <= yoe365 + {11'd0, s7_yoe_q[8:2]};
      s8_y100_q <= y100_prod[18:16];
      s8_tm_q   <= s7_tm_q;
    end
  end

  // Stage 9: day of the March-based year.
  logic [17:0] doy_full;
  logic [8:0]  s9_doy_q;
  logic [8:0]  s9_yoe_q;
  hms_t        s9_tm_q;

  assign doy_full = s8_doe_q - s8_base_q + {15'd0, s8_y100_q};

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_doy_q <= doy_full[8:0];
      s9_yoe_q <= s8_yoe_q;
      s9_tm_q  <= s8_tm_q;
    end
  end

  // Stage 10: month of the March-based year.
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic [8:0]  s10_doy_q;
  logic [3:0]  s10_mp_q;
  logic [8:0]  s10_yoe_q;
  hms_t        s10_tm_q;

  assign mp_num  = {2'b00, s9_doy_q} * 11'd5 + 11'd2;
  assign mp_prod = mp_num * D153_M;

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s10_doy_q <= s9_doy_q;
      s10_mp_q  <= mp_prod[22:19];
      s10_yoe_q <= s9_yoe_q;
      s10_tm_q  <= s9_tm_q;
    end
  end

  // Stage 11: output register with day, month and year of century.
  logic [8:0] day_full;
  logic [3:0] month_w;
  logic       jan_feb;
  logic [8:0] year_w;
  logic [8:0] year_mod;
  hms_t       s11_tm_q;
  logic [4:0] s11_day_q;
  logic [3:0] s11_month_q;
  logic [6:0] s11_year_q;

  assign day_full = s10_doy_q - month_start(s10_mp_q) + 9'd1;
  assign jan_feb  = (s10_mp_q >= 4'd10);
  assign month_w  = jan_feb ? s10_mp_q - 4'd9 : s10_mp_q + 4'd3;
  assign year_w   = s10_yoe_q + {8'd0, jan_feb};

  always_comb begin
    if (year_w >= 9'd400) begin
      year_mod = year_w - 9'd400;
    end else if (year_w >= 9'd300) begin
      year_mod = year_w - 9'd300;
    end else if (year_w >= 9'd200) begin
      year_mod = year_w - 9'd200;
    end else if (year_w >= 9'd100) begin
      year_mod = year_w - 9'd100;
    end else begin
      year_mod = year_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      s11_tm_q    <= s10_tm_q;
      s11_day_q   <= day_full[4:0];
      s11_month_q <= month_w;
      s11_year_q  <= year_mod[6:0];
    end
  end

  assign cal_o.hour_of_day      = s11_tm_q.hour;
  assign cal_o.minute_of_hour   = s11_tm_q.minute;
  assign cal_o.second_of_minute = s11_tm_q.second;
  assign cal_o.day_of_month     = s11_day_q;
  assign cal_o.month_number     = s11_month_q;
  assign cal_o.year_of_century  = s11_year_q;

  // Checks.
  logic in_fire;
  logic out_fire;

  assign in_fire  = sec_i.valid && sec_i.ready;
  assign out_fire = cal_o.valid && cal_o.ready;

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_o.valid |-> (cal_o.hour_of_day < 5'd24) && (cal_o.minute_of_hour < 6'd60)
                 && (cal_o.second_of_minute < 6'd60))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_o.valid |-> (cal_o.day_of_month != 5'd0) && (cal_o.month_number != 4'd0)
                 && (cal_o.month_number <= 4'd12) && (cal_o.year_of_century < 7'd100))
    else $error("date out of range");

  a_february: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cal_o.valid && cal_o.month_number == 4'd2) |-> (cal_o.day_of_month <= 5'd29))
    else $error("day beyond the end of February");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_fire) |=> ($countones(v_q) == $past($countones(v_q)) + 1))
    else $error("transaction lost or duplicated in the pipeline");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && out_fire) |=> ($countones(v_q) + 1 == $past($countones(v_q))))
    else $error("transaction lost or duplicated in the pipeline");

endmodule
